FILE: design/stkf_pkg.sv
// Package for the strong-tracking Kalman smoother: widths, fixed-point constants,
// register codes, the shared arithmetic unit's control structs and a saturating add.
// No dependencies.
`timescale 1ns / 1ps

package stkf_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int SMP_W      = 24;
  localparam int EST_W      = SMP_W + FRAC_BITS;   // 40
  localparam int INN_W      = EST_W + 2;           // innovation and its mean, with margin
  localparam int VAR_W      = 64;
  localparam int GAIN_W     = 17;
  localparam int FAD_W      = 20;
  localparam int CNT_W      = 5;
  localparam int WARMUP     = 30;
  localparam int OPA_W      = VAR_W + FRAC_BITS;   // dividend width
  localparam int DIV_Q_BITS = 22;                  // every quotient here stays below 2^22
  localparam int MUL_STEPS  = 4;                   // 32x32 partial products

  localparam logic [GAIN_W-1:0] ONE      = GAIN_W'(1 << FRAC_BITS);
  localparam logic [GAIN_W-1:0] C_015    = GAIN_W'(((15 << FRAC_BITS) + 50) / 100);
  localparam logic [GAIN_W-1:0] C_008    = GAIN_W'(((8 << FRAC_BITS) + 50) / 100);
  localparam logic [GAIN_W-1:0] C_002    = GAIN_W'(((2 << FRAC_BITS) + 50) / 100);
  localparam logic [GAIN_W-1:0] C_080    = GAIN_W'(((8 << FRAC_BITS) + 5) / 10);
  localparam logic [GAIN_W-1:0] C_120    = GAIN_W'(((12 << FRAC_BITS) + 5) / 10);
  localparam logic [GAIN_W-1:0] C_090    = GAIN_W'(((9 << FRAC_BITS) + 5) / 10);
  localparam logic [FAD_W-1:0]  LAM_MAX  = FAD_W'(10 << FRAC_BITS);
  localparam logic [23:0]       WG_NUM   = 24'(120 << FRAC_BITS);   // 2 * 60 * ONE
  localparam logic [8:0]        WG_BASE  = 9'd100;

  localparam logic [16:0] QN_DEF   = 17'(((1 << FRAC_BITS) + 50) / 100);
  localparam logic [19:0] RN_DEF   = 20'(1 << FRAC_BITS);
  localparam logic [19:0] RN_MAX   = 20'(10 << FRAC_BITS);
  localparam logic [16:0] RHO_DEF  = 17'(((95 << FRAC_BITS) + 50) / 100);
  localparam logic [23:0] BETA_DEF = 24'(2 << FRAC_BITS);
  localparam logic [23:0] THR_DEF  = 24'(3 << FRAC_BITS);

  typedef enum logic [2:0] {
    CFG_PROCESS_NOISE     = 3'd0,
    CFG_MEASUREMENT_NOISE = 3'd1,
    CFG_FORGETTING_FACTOR = 3'd2,
    CFG_WEAKENING_FACTOR  = 3'd3,
    CFG_TRACK_THRESHOLD   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic start;
    logic is_div;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic [VAR_W-1:0] result;
  } alu_rsp_t;

  function automatic logic [VAR_W-1:0] sat_add(input logic [VAR_W-1:0] a,
                                               input logic [VAR_W-1:0] b);
    logic [VAR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VAR_W] ? '1 : s[VAR_W-1:0];
  endfunction

endpackage

FILE: design/stkf_if.sv
// Request and result channel interfaces for the strong-tracking Kalman smoother.
// Depends on stkf_pkg for the field widths.
`timescale 1ns / 1ps

interface stkf_in_if;
  import stkf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic signed [SMP_W-1:0] sample_value;
  modport source(output valid, command, sample_value, input ready);
  modport sink(input valid, command, sample_value, output ready);
endinterface

interface stkf_out_if;
  import stkf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [EST_W-1:0] estimate;
  logic                    tracking;
  logic [GAIN_W-1:0]       gain_now;
  logic [FAD_W-1:0]        fading_now;
  logic                    warming_up;
  modport source(output valid, estimate, tracking, gain_now, fading_now, warming_up,
                 input ready);
  modport sink(input valid, estimate, tracking, gain_now, fading_now, warming_up,
               output ready);
endinterface

FILE: design/stkf_alu.sv
// Shared arithmetic unit: truncating Q.16 multiply with saturation built from
// 32x32 partial products, and a restoring divider producing one quotient bit a cycle.
// Depends on stkf_pkg.
`timescale 1ns / 1ps

module stkf_alu (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  stkf_pkg::alu_req_t           req_i,
  input  logic [stkf_pkg::OPA_W-1:0]   opa_i,
  input  logic [stkf_pkg::VAR_W-1:0]   opb_i,
  output stkf_pkg::alu_rsp_t           rsp_o
);
  import stkf_pkg::*;

  typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_DONE} alu_state_e;

  alu_state_e              state_q;
  logic [CNT_W-1:0]        step_q;
  logic                    div_q;
  logic [OPA_W-1:0]        a_q;
  logic [VAR_W-1:0]        b_q;
  logic [2*VAR_W-1:0]      acc_q;
  logic [VAR_W-1:0]        rem_q;
  logic [DIV_Q_BITS-1:0]   quo_q;

  logic [31:0]             a_part, b_part;
  logic [VAR_W-1:0]        pp;
  logic [2*VAR_W-1:0]      pp_sh;
  logic [VAR_W:0]          trial, trial_sub;
  logic                    trial_ge;

  always_comb begin
    a_part = step_q[1] ? a_q[63:32] : a_q[31:0];
    b_part = step_q[0] ? b_q[63:32] : b_q[31:0];
    pp     = a_part * b_part;
    case ({1'b0, step_q[1]} + {1'b0, step_q[0]})
      2'd0:    pp_sh = {64'd0, pp};
      2'd1:    pp_sh = {32'd0, pp, 32'd0};
      default: pp_sh = {pp, 64'd0};
    endcase
    trial     = {rem_q, a_q[OPA_W-1]};
    trial_ge  = trial >= {1'b0, b_q};
    trial_sub = trial - {1'b0, b_q};
  end

  assign rsp_o.done   = (state_q == A_DONE);
  assign rsp_o.result = div_q ? VAR_W'(quo_q)
                      : (|acc_q[2*VAR_W-1:VAR_W+FRAC_BITS]) ? '1
                      : acc_q[VAR_W+FRAC_BITS-1:FRAC_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      step_q  <= '0;
    end else begin
      case (state_q)
        A_IDLE: begin
          if (req_i.start) begin
            div_q  <= req_i.is_div;
            step_q <= '0;
            b_q    <= opb_i;
            if (req_i.is_div) begin
              rem_q   <= VAR_W'(opa_i[OPA_W-1:DIV_Q_BITS]);
              a_q     <= {opa_i[DIV_Q_BITS-1:0], (OPA_W-DIV_Q_BITS)'(0)};
              quo_q   <= '0;
              state_q <= A_DIV;
            end else begin
              a_q     <= opa_i;
              acc_q   <= '0;
              state_q <= A_MUL;
            end
          end
        end
        A_MUL: begin
          acc_q  <= acc_q + pp_sh;
          step_q <= step_q + 1'b1;
          if (step_q == CNT_W'(MUL_STEPS - 1)) state_q <= A_DONE;
        end
        A_DIV: begin
          a_q    <= a_q << 1;
          step_q <= step_q + 1'b1;
          if (trial_ge) begin
            rem_q <= trial_sub[VAR_W-1:0];
            quo_q <= {quo_q[DIV_Q_BITS-2:0], 1'b1};
          end else begin
            rem_q <= trial[VAR_W-1:0];
            quo_q <= {quo_q[DIV_Q_BITS-2:0], 1'b0};
          end
          if (step_q == CNT_W'(DIV_Q_BITS - 1)) state_q <= A_DONE;
        end
        default: state_q <= A_IDLE;
      endcase
    end
  end

endmodule

FILE: design/strong_tracking_kalman_filter_unit.sv
// Top level of the strong-tracking scalar Kalman smoother for load-cell samples.
// Depends on stkf_pkg, stkf_in_if / stkf_out_if and the shared unit stkf_alu.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake          Carries
//  req_i     in         valid / ready      command, sample_value
//  rsp_o     out        valid / ready      estimate, tracking, gain_now, fading_now,
//                                          warming_up
//  cfg_*     in         write enable only  register index and data
//
// A restart request goes from idle straight to the output state. A filter request
// runs every step through one shared unit, as multiplies and divides, fewer of them
// during warm-up than once settled; a settled request issues two divides.
// Reset is asynchronous and active low; it loads the register defaults and the
// filter state of a restart at zero. A waiting result does not block the next
// request; only when the next result is ready and the output is still full does
// the sequencer hold.

module strong_tracking_kalman_filter_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  stkf_in_if.sink       req_i,
  stkf_out_if.source    rsp_o,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [23:0]   cfg_data_i
);
  import stkf_pkg::*;

  // One state per operation issued to the shared unit, plus the idle and output states.
  typedef enum logic [4:0] {
    S_IDLE, S_SQ, S_AVG, S_SPR1, S_SPR2, S_WGAIN, S_COV1, S_COV2, S_BR, S_LAM,
    S_LAMSC, S_PSC, S_GAIN, S_THR2, S_RHS, S_LHS, S_EST, S_PV, S_FIN
  } seq_state_e;

  seq_state_e state_q;
  logic       issue_q;

  // Configuration registers.
  logic [16:0] qn_q, rho_q;
  logic [19:0] rn_q;
  logic [23:0] beta_q, thr_q;

  // Filter state.
  logic signed [EST_W-1:0] est_q;
  logic signed [INN_W-1:0] avg_q, inn_q;
  logic [VAR_W-1:0]        pv_q, cov_q, spr_q, ppred_q, sq_q, tmp_q;
  logic [FAD_W-1:0]        fad_q;
  logic [GAIN_W-1:0]       gain_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    trk_q, warm_q;

  // Output register.
  logic                    out_valid_q;
  logic signed [EST_W-1:0] out_est_q;
  logic                    out_trk_q, out_warm_q;
  logic [GAIN_W-1:0]       out_gain_q;
  logic [FAD_W-1:0]        out_fad_q;

  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;
  logic [OPA_W-1:0] opa;
  logic [VAR_W-1:0] opb;

  logic                    in_fire, skip;
  logic signed [EST_W-1:0] meas;
  logic [CNT_W-1:0]        cnt_n;
  logic [GAIN_W-1:0]       alpha;
  logic signed [INN_W:0]   dif;
  logic [INN_W:0]          dif_mag;
  logic [INN_W-1:0]        inn_mag;
  logic [VAR_W-1:0]        m_w, gden;
  logic [VAR_W+3:0]        ten_m;
  logic                    lam_big, sq_gt, sq_lt;
  logic [8:0]              wden;
  logic signed [INN_W:0]   avg_sum;
  logic signed [INN_W:0]   est_sum;
  logic signed [INN_W:0]   res_s;
  logic                    est_fits;

  stkf_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .opa_i  (opa),
    .opb_i  (opb),
    .rsp_o  (alu_rsp)
  );

  assign req_i.ready       = (state_q == S_IDLE);
  assign in_fire           = req_i.valid && req_i.ready;
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.estimate    = out_est_q;
  assign rsp_o.tracking    = out_trk_q;
  assign rsp_o.gain_now    = out_gain_q;
  assign rsp_o.fading_now  = out_fad_q;
  assign rsp_o.warming_up  = out_warm_q;

  always_comb begin
    meas    = {req_i.sample_value, FRAC_BITS'(0)};
    cnt_n   = (cnt_q == CNT_W'(WARMUP)) ? cnt_q : cnt_q + 1'b1;
    alpha   = warm_q ? C_015 : C_008;
    // Difference of the innovation from its running mean; after the mean update it
    // is also the distance used by the tracking test.
    dif     = (INN_W+1)'(inn_q) - (INN_W+1)'(avg_q);
    dif_mag = dif[INN_W] ? (INN_W+1)'(-dif) : (INN_W+1)'(dif);
    inn_mag = inn_q[INN_W-1] ? INN_W'(-inn_q) : INN_W'(inn_q);
    m_w     = (pv_q == '0) ? VAR_W'(1) : pv_q;
    ten_m   = ({4'b0, m_w} << 3) + ({4'b0, m_w} << 1);
    lam_big = {4'b0, tmp_q} >= ten_m;
    sq_gt   = sq_q > VAR_W'({rn_q, 4'b0});
    sq_lt   = sq_q < VAR_W'(rn_q);
    gden    = sat_add(ppred_q, VAR_W'(rn_q));
    wden    = WG_BASE + 9'({cnt_q, 1'b0}) + 9'(cnt_q);
    res_s   = $signed({1'b0, alu_rsp.result[INN_W-1:0]});
    avg_sum = (INN_W+1)'(avg_q) + (dif[INN_W] ? -res_s : res_s);
    est_sum = (INN_W+1)'(est_q) + (inn_q[INN_W-1] ? -res_s : res_s);
    est_fits = (est_sum[INN_W:EST_W-1] == {(INN_W-EST_W+2){est_sum[EST_W-1]}});

    // Operand selection for the shared unit.
    opa = '0;
    opb = '0;
    alu_req.is_div = 1'b0;
    skip = 1'b0;
    case (state_q)
      S_SQ:    begin opa = OPA_W'(inn_mag);        opb = VAR_W'(inn_mag); end
      S_AVG:   begin opa = OPA_W'(alpha);          opb = VAR_W'(dif_mag); end
      S_SPR1:  begin opa = OPA_W'(ONE - alpha);    opb = spr_q;           end
      S_SPR2:  begin opa = OPA_W'(alpha);          opb = sq_q;            end
      S_WGAIN: begin
        alu_req.is_div = 1'b1;
        opa = OPA_W'(WG_NUM) + OPA_W'(wden);
        opb = VAR_W'({wden, 1'b0});
      end
      S_COV1:  begin opa = OPA_W'(rho_q);          opb = cov_q;           end
      S_COV2:  begin opa = OPA_W'(ONE - rho_q);    opb = sq_q;            end
      S_BR:    begin opa = OPA_W'(beta_q);         opb = VAR_W'(rn_q);    end
      S_LAM: begin
        alu_req.is_div = 1'b1;
        opa  = {tmp_q, FRAC_BITS'(0)};
        opb  = m_w;
        skip = lam_big;
      end
      S_LAMSC: begin
        opa  = OPA_W'(fad_q);
        opb  = VAR_W'(sq_gt ? C_120 : C_090);
        skip = !(sq_gt || sq_lt);
      end
      S_PSC:   begin opa = OPA_W'(ppred_q);        opb = VAR_W'(fad_q);   end
      S_GAIN: begin
        alu_req.is_div = 1'b1;
        opa = {ppred_q, FRAC_BITS'(0)};
        opb = gden;
      end
      S_THR2: begin
        opa  = OPA_W'(thr_q);
        opb  = VAR_W'(thr_q);
        skip = (dif_mag == '0);
      end
      S_RHS:   begin opa = OPA_W'(tmp_q);          opb = spr_q;           end
      S_LHS:   begin opa = OPA_W'(dif_mag);        opb = VAR_W'(dif_mag); end
      S_EST:   begin opa = OPA_W'(gain_q);         opb = VAR_W'(inn_mag); end
      S_PV:    begin opa = OPA_W'(ONE - gain_q);   opb = ppred_q;         end
      default: skip = 1'b1;
    endcase
    alu_req.start = !issue_q && !skip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issue_q     <= 1'b0;
      out_valid_q <= 1'b0;
      qn_q        <= QN_DEF;
      rn_q        <= RN_DEF;
      rho_q       <= RHO_DEF;
      beta_q      <= BETA_DEF;
      thr_q       <= THR_DEF;
      est_q       <= '0;
      pv_q        <= VAR_W'(ONE);
      gain_q      <= '0;
      fad_q       <= FAD_W'(ONE);
      cov_q       <= VAR_W'(RN_DEF);
      spr_q       <= VAR_W'(RN_DEF);
      avg_q       <= '0;
      cnt_q       <= '0;
      trk_q       <= 1'b1;
      warm_q      <= 1'b1;
    end else begin
      // Register writes must arrive only while the sequencer is idle; the block itself does
      // not enforce this. Values outside the legal range fall back to the default.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PROCESS_NOISE:
            qn_q <= (cfg_data_i[16:0] != '0 && cfg_data_i[16:0] <= ONE)
                    ? cfg_data_i[16:0] : QN_DEF;
          CFG_MEASUREMENT_NOISE:
            rn_q <= (cfg_data_i[19:0] != '0 && cfg_data_i[19:0] <= RN_MAX)
                    ? cfg_data_i[19:0] : RN_DEF;
          CFG_FORGETTING_FACTOR:
            rho_q <= (cfg_data_i[16:0] != '0 && cfg_data_i[16:0] <= ONE)
                     ? cfg_data_i[16:0] : RHO_DEF;
          CFG_WEAKENING_FACTOR:
            beta_q <= (cfg_data_i >= 24'(ONE)) ? cfg_data_i : BETA_DEF;
          CFG_TRACK_THRESHOLD:
            thr_q <= cfg_data_i;
          default: ;
        endcase
      end

      // In S_FIN the output register is reloaded below whenever it is taken.
      if (rsp_o.valid && rsp_o.ready && state_q != S_FIN) out_valid_q <= 1'b0;

      if (alu_req.start) issue_q <= 1'b1;
      if (alu_rsp.done)  issue_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (req_i.command) begin
              // Restart: the whole filter state starts over at the given value.
              est_q   <= meas;
              pv_q    <= VAR_W'(ONE);
              gain_q  <= '0;
              fad_q   <= FAD_W'(ONE);
              cov_q   <= VAR_W'(rn_q);
              spr_q   <= VAR_W'(rn_q);
              avg_q   <= '0;
              cnt_q   <= '0;
              trk_q   <= 1'b1;
              warm_q  <= 1'b1;
              state_q <= S_FIN;
            end else begin
              cnt_q   <= cnt_n;
              warm_q  <= (cnt_n < CNT_W'(WARMUP));
              ppred_q <= sat_add(pv_q, VAR_W'(qn_q));
              inn_q   <= INN_W'(meas) - INN_W'(est_q);
              state_q <= S_SQ;
            end
          end
        end
        S_SQ: if (alu_rsp.done) begin
          sq_q <= alu_rsp.result;
          if (warm_q && cnt_q == CNT_W'(1)) begin
            // First sample after a restart seeds the innovation statistics.
            avg_q   <= inn_q;
            spr_q   <= VAR_W'(rn_q);
            state_q <= S_WGAIN;
          end else begin
            state_q <= S_AVG;
          end
        end
        S_AVG: if (alu_rsp.done) begin
          avg_q   <= avg_sum[INN_W-1:0];
          state_q <= S_SPR1;
        end
        S_SPR1: if (alu_rsp.done) begin
          tmp_q   <= alu_rsp.result;
          state_q <= S_SPR2;
        end
        S_SPR2: if (alu_rsp.done) begin
          spr_q   <= sat_add(tmp_q, alu_rsp.result);
          state_q <= warm_q ? S_WGAIN : S_COV1;
        end
        S_WGAIN: if (alu_rsp.done) begin
          gain_q  <= alu_rsp.result[GAIN_W-1:0];
          state_q <= S_EST;
        end
        S_COV1: if (alu_rsp.done) begin
          tmp_q   <= alu_rsp.result;
          state_q <= S_COV2;
        end
        S_COV2: if (alu_rsp.done) begin
          cov_q   <= sat_add(tmp_q, alu_rsp.result);
          state_q <= S_BR;
        end
        S_BR: if (alu_rsp.done) begin
          // Numerator of the fading factor: covariance in excess of beta * R.
          tmp_q   <= (cov_q > alu_rsp.result) ? cov_q - alu_rsp.result : '0;
          state_q <= S_LAM;
        end
        S_LAM: begin
          if (skip && !issue_q) begin
            fad_q   <= LAM_MAX;
            state_q <= S_LAMSC;
          end else if (alu_rsp.done) begin
            fad_q   <= (alu_rsp.result < VAR_W'(ONE)) ? FAD_W'(ONE)
                                                      : alu_rsp.result[FAD_W-1:0];
            state_q <= S_LAMSC;
          end
        end
        S_LAMSC: begin
          if (skip && !issue_q) begin
            state_q <= S_PSC;
          end else if (alu_rsp.done) begin
            fad_q   <= alu_rsp.result[FAD_W-1:0];
            state_q <= S_PSC;
          end
        end
        S_PSC: if (alu_rsp.done) begin
          ppred_q <= alu_rsp.result;
          state_q <= S_GAIN;
        end
        S_GAIN: if (alu_rsp.done) begin
          if (alu_rsp.result < VAR_W'(C_002))      gain_q <= C_002;
          else if (alu_rsp.result > VAR_W'(C_080)) gain_q <= C_080;
          else                                     gain_q <= alu_rsp.result[GAIN_W-1:0];
          state_q <= S_THR2;
        end
        S_THR2: begin
          if (skip && !issue_q) begin
            // Innovation sits exactly on its mean.
            trk_q   <= (thr_q != '0);
            state_q <= S_EST;
          end else if (alu_rsp.done) begin
            tmp_q   <= alu_rsp.result;
            state_q <= S_RHS;
          end
        end
        S_RHS: if (alu_rsp.done) begin
          tmp_q   <= alu_rsp.result;
          state_q <= S_LHS;
        end
        S_LHS: if (alu_rsp.done) begin
          trk_q   <= (alu_rsp.result < tmp_q);
          state_q <= S_EST;
        end
        S_EST: if (alu_rsp.done) begin
          if (est_fits)           est_q <= est_sum[EST_W-1:0];
          else if (est_sum[INN_W]) est_q <= {1'b1, (EST_W-1)'(0)};
          else                    est_q <= {1'b0, {(EST_W-1){1'b1}}};
          state_q <= S_PV;
        end
        S_PV: if (alu_rsp.done) begin
          pv_q    <= alu_rsp.result;
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q <= 1'b1;
            out_est_q   <= est_q;
            out_trk_q   <= trk_q;
            out_gain_q  <= gain_q;
            out_fad_q   <= fad_q;
            out_warm_q  <= warm_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
